@@ design/particle_update_step_top_assert.svh @@
// Assertion macros for the particle update step design, used by pus_ctrl.
`ifndef PARTICLE_UPDATE_STEP_TOP_ASSERT_SVH
`define PARTICLE_UPDATE_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PUS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("particle_update_step: assertion failed");
`define PUS_ASSERT_RESET(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("particle_update_step: reset assertion failed");
`else
`define PUS_ASSERT(label, prop)
`define PUS_ASSERT_RESET(label, prop)
`endif
`endif

@@ design/pus_pkg.sv @@
// Types, stage map and helpers of the particle update step pipeline.
package pus_pkg;

  localparam int ST_IN      = 0;
  localparam int ST_MV1     = 1;
  localparam int ST_MV2     = 2;
  localparam int ST_MV3     = 3;
  localparam int ST_MO      = 4;
  localparam int ST_RAMP0   = 1;
  localparam int RAMP_STEPS = 17;
  localparam int ST_RAMP    = ST_RAMP0 + RAMP_STEPS;
  localparam int ST_FADE0   = ST_RAMP + 1;
  localparam int FADE_STEPS = 16;
  localparam int ST_FADE    = ST_FADE0 + FADE_STEPS - 1;
  localparam int ST_RAD0    = ST_FADE0;
  localparam int ST_RAD     = ST_RAD0 + 1;
  localparam int ST_P1      = ST_FADE + 1;
  localparam int ST_P2      = ST_P1 + 1;
  localparam int ST_OUT     = ST_P2 + 1;
  localparam int NS         = ST_OUT + 1;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [3:0] {
    CFG_GRAVITY      = 4'd0,
    CFG_DRAG         = 4'd1,
    CFG_LIFE_TIME    = 4'd2,
    CFG_FADE_IN      = 4'd3,
    CFG_FADE_OUT     = 4'd4,
    CFG_MAX_ALPHA    = 4'd5,
    CFG_START_RADIUS = 4'd6,
    CFG_END_RADIUS   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] gravity;
    logic [17:0] drag;
    logic [31:0] life_time;
    logic [16:0] fade_in;
    logic [16:0] fade_out;
    logic [16:0] max_alpha;
    logic [31:0] start_radius;
    logic [31:0] end_radius;
  } cfg_t;

  typedef struct packed {
    logic             alive;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [30:0]      age;
    logic [15:0]      dt;
  } particle_t;

  typedef struct packed {
    logic             live;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
  } motion_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/pus_ctrl.sv @@
// Stage valid bits and per-stage load enables with bubble collapse.
`include "particle_update_step_top_assert.svh"
module pus_ctrl import pus_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [NS-1:0] ld
);

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] rdy;
  logic [NS-1:0] src;
  logic          in_beat;
  logic          out_beat;
  int            fill;

  always_comb begin
    src = {v_r[NS-2:0], in_valid};
    for (int i = 0; i < NS; i++) begin
      rdy[i] = out_ready | ~&(v_r | ~({NS{1'b1}} << i));
    end
    ld = rdy & src;
    for (int i = 0; i < NS; i++) begin
      v_nxt[i] = rdy[i] ? src[i] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign in_beat   = in_valid & in_ready;
  assign out_beat  = out_valid & out_ready;
  assign fill      = $countones(v_r);

  `PUS_ASSERT_RESET(a_empty_after_reset, !rst_n |=> (v_r == '0))
  `PUS_ASSERT(a_stall_only_when_full, !in_ready |-> (&v_r))
  `PUS_ASSERT(a_beat_count, $past(rst_n) |-> (fill == $past(fill) + $past(in_beat) - $past(out_beat)))

endmodule

@@ design/pus_motion.sv @@
// Position and velocity integration with drag, aligned to the output stage.
module pus_motion import pus_pkg::*; (
  input  logic          clk,
  input  logic [NS-1:0] ld,
  input  particle_t     p,
  input  cfg_t          cfg,
  output motion_t       mo
);

  logic signed [16:0] dts;
  logic signed [18:0] dm;
  logic signed [15:0] g [3];
  logic               live;

  logic               live1_r;
  logic signed [31:0] pos1_r [3];
  logic signed [31:0] vel1_r [3];
  logic signed [48:0] pv1_r  [3];
  logic signed [32:0] pg1_r  [3];
  logic signed [35:0] pd1_r;

  logic signed [33:0] dpos [3];
  logic signed [34:0] psum [3];
  logic signed [25:0] dvel [3];
  logic signed [33:0] vsum [3];
  logic signed [20:0] mr;

  logic               live2_r;
  logic signed [31:0] pos2_r [3];
  logic signed [31:0] vel2_r [3];
  logic signed [31:0] v1_2_r [3];
  logic signed [19:0] m2_r;

  logic               live3_r;
  logic signed [31:0] pos3_r [3];
  logic signed [31:0] vel3_r [3];
  logic signed [51:0] pm3_r  [3];

  motion_t            mo_nxt;
  motion_t            mo_r [ST_MO:NS-1];

  always_comb begin
    dts  = $signed({1'b0, p.dt});
    dm   = 19'sd65536 - $signed({1'b0, cfg.drag});
    live = p.alive & ({1'b0, p.age} <= cfg.life_time);
    for (int i = 0; i < 3; i++) begin
      g[i] = $signed(cfg.gravity[16*i +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_MV1]) begin
      live1_r <= live;
      pd1_r   <= dm * dts;
      for (int i = 0; i < 3; i++) begin
        pos1_r[i] <= $signed(p.pos[i]);
        vel1_r[i] <= $signed(p.vel[i]);
        pv1_r[i]  <= $signed(p.vel[i]) * dts;
        pg1_r[i]  <= g[i] * dts;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dpos[i] = 34'((pv1_r[i] + 49'sd32768) >>> 16);
      psum[i] = 35'(pos1_r[i]) + 35'(dpos[i]);
      dvel[i] = 26'(((41'(pg1_r[i]) <<< 8) + 41'sd32768) >>> 16);
      vsum[i] = 34'(vel1_r[i]) + 34'(dvel[i]);
    end
    mr = 21'((pd1_r + 36'sd32768) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_MV2]) begin
      live2_r <= live1_r;
      m2_r    <= 20'(21'sd65536 - mr);
      for (int i = 0; i < 3; i++) begin
        pos2_r[i] <= live1_r ? sat32(64'(psum[i])) : pos1_r[i];
        vel2_r[i] <= vel1_r[i];
        v1_2_r[i] <= sat32(64'(vsum[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_MV3]) begin
      live3_r <= live2_r;
      for (int i = 0; i < 3; i++) begin
        pos3_r[i] <= pos2_r[i];
        vel3_r[i] <= vel2_r[i];
        pm3_r[i]  <= v1_2_r[i] * m2_r;
      end
    end
  end

  always_comb begin
    mo_nxt.live = live3_r;
    for (int i = 0; i < 3; i++) begin
      mo_nxt.pos[i] = pos3_r[i];
      mo_nxt.vel[i] = live3_r ? sat32(64'((pm3_r[i] + 52'sd32768) >>> 16)) : vel3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_MO]) begin
      mo_r[ST_MO] <= mo_nxt;
    end
    for (int s = ST_MO + 1; s < NS; s++) begin
      if (ld[s]) begin
        mo_r[s] <= mo_r[s-1];
      end
    end
  end

  assign mo = mo_r[NS-1];

endmodule

@@ design/pus_ramp_div.sv @@
// Pipelined restoring divider for the life ramp, one quotient bit per stage.
module pus_ramp_div import pus_pkg::*; (
  input  logic          clk,
  input  logic [NS-1:0] ld,
  input  logic [30:0]   age,
  input  logic [31:0]   life_time,
  output logic [16:0]   ramp
);

  logic [31:0] rin_w   [1:RAMP_STEPS];
  logic [16:0] qin_w   [1:RAMP_STEPS];
  logic        b_w     [1:RAMP_STEPS];
  logic [32:0] t_w     [1:RAMP_STEPS];
  logic        ge_w    [1:RAMP_STEPS];
  logic [31:0] rem_nxt [1:RAMP_STEPS];
  logic [16:0] q_nxt   [1:RAMP_STEPS];
  logic [31:0] rem_r   [1:RAMP_STEPS];
  logic [16:0] q_r     [1:RAMP_STEPS];
  logic [16:0] ramp_r;

  always_comb begin
    rin_w[1] = {2'b00, age[30:1]};
    qin_w[1] = '0;
    b_w[1]   = age[0];
    for (int j = 2; j <= RAMP_STEPS; j++) begin
      rin_w[j] = rem_r[j-1];
      qin_w[j] = q_r[j-1];
      b_w[j]   = 1'b0;
    end
    for (int j = 1; j <= RAMP_STEPS; j++) begin
      t_w[j]     = {rin_w[j], b_w[j]};
      ge_w[j]    = t_w[j] >= {1'b0, life_time};
      rem_nxt[j] = ge_w[j] ? 32'(t_w[j] - {1'b0, life_time}) : t_w[j][31:0];
      q_nxt[j]   = {qin_w[j][15:0], ge_w[j]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 1; j <= RAMP_STEPS; j++) begin
      if (ld[ST_RAMP0 - 1 + j]) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
    end
    if (ld[ST_RAMP]) begin
      if (life_time == '0 || q_r[RAMP_STEPS] > ONE_Q16) begin
        ramp_r <= ONE_Q16;
      end else begin
        ramp_r <= q_r[RAMP_STEPS];
      end
    end
  end

  assign ramp = ramp_r;

endmodule

@@ design/pus_fade_div.sv @@
// Pipelined restoring divider for a fade factor, one quotient bit per stage.
module pus_fade_div import pus_pkg::*; (
  input  logic          clk,
  input  logic [NS-1:0] ld,
  input  logic [16:0]   num,
  input  logic [16:0]   den,
  output logic [15:0]   q
);

  logic [16:0] rin_w   [1:FADE_STEPS];
  logic [15:0] qin_w   [1:FADE_STEPS];
  logic [17:0] t_w     [1:FADE_STEPS];
  logic        ge_w    [1:FADE_STEPS];
  logic [16:0] rem_nxt [1:FADE_STEPS];
  logic [15:0] q_nxt   [1:FADE_STEPS];
  logic [16:0] rem_r   [1:FADE_STEPS];
  logic [15:0] q_r     [1:FADE_STEPS];

  always_comb begin
    rin_w[1] = num;
    qin_w[1] = '0;
    for (int j = 2; j <= FADE_STEPS; j++) begin
      rin_w[j] = rem_r[j-1];
      qin_w[j] = q_r[j-1];
    end
    for (int j = 1; j <= FADE_STEPS; j++) begin
      t_w[j]     = {rin_w[j], 1'b0};
      ge_w[j]    = t_w[j] >= {1'b0, den};
      rem_nxt[j] = ge_w[j] ? 17'(t_w[j] - {1'b0, den}) : t_w[j][16:0];
      q_nxt[j]   = {qin_w[j][14:0], ge_w[j]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 1; j <= FADE_STEPS; j++) begin
      if (ld[ST_FADE0 - 1 + j]) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign q = q_r[FADE_STEPS];

endmodule

@@ design/pus_shade.sv @@
// Fade factors, opacity and radius from the life ramp.
module pus_shade import pus_pkg::*; (
  input  logic          clk,
  input  logic [NS-1:0] ld,
  input  logic [16:0]   ramp,
  input  cfg_t          cfg,
  output logic [16:0]   opacity,
  output logic [31:0]   radius
);

  logic               fin_need_w;
  logic               fout_need_w;
  logic [16:0]        fout_num_w;
  logic [1:0]         need_r [ST_FADE0:ST_FADE];
  logic [15:0]        q_fin;
  logic [15:0]        q_fout;

  logic signed [32:0] diff_w;
  logic signed [50:0] rp_r;
  logic signed [34:0] rad_w;
  logic [31:0]        rad_nxt;
  logic [31:0]        rad_r [ST_RAD:ST_OUT];

  logic [16:0]        fin_w;
  logic [16:0]        fout_w;
  logic [33:0]        p1_r;
  logic [34:0]        p2_r;
  logic [16:0]        op_r;

  always_comb begin
    fin_need_w  = ramp < cfg.fade_in;
    fout_need_w = (cfg.fade_out != '0) &&
                  ((18'(ramp) + 18'(cfg.fade_out)) > 18'(ONE_Q16));
    fout_num_w  = 17'(ONE_Q16 - ramp);
  end

  pus_fade_div u_fin (
    .clk (clk),
    .ld  (ld),
    .num (ramp),
    .den (cfg.fade_in),
    .q   (q_fin)
  );

  pus_fade_div u_fout (
    .clk (clk),
    .ld  (ld),
    .num (fout_num_w),
    .den (cfg.fade_out),
    .q   (q_fout)
  );

  always_ff @(posedge clk) begin
    if (ld[ST_FADE0]) begin
      need_r[ST_FADE0] <= {fin_need_w, fout_need_w};
    end
    for (int s = ST_FADE0 + 1; s <= ST_FADE; s++) begin
      if (ld[s]) begin
        need_r[s] <= need_r[s-1];
      end
    end
  end

  always_comb begin
    diff_w = $signed({1'b0, cfg.end_radius}) - $signed({1'b0, cfg.start_radius});
    rad_w  = 35'($signed({1'b0, cfg.start_radius})) +
             35'((rp_r + 51'sd32768) >>> 16);
    if (rad_w < 35'sd0) begin
      rad_nxt = '0;
    end else if (rad_w > 35'sh0FFFFFFFF) begin
      rad_nxt = 32'hFFFFFFFF;
    end else begin
      rad_nxt = rad_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_RAD0]) begin
      rp_r <= diff_w * $signed({1'b0, ramp});
    end
    if (ld[ST_RAD]) begin
      rad_r[ST_RAD] <= rad_nxt;
    end
    for (int s = ST_RAD + 1; s <= ST_OUT; s++) begin
      if (ld[s]) begin
        rad_r[s] <= rad_r[s-1];
      end
    end
  end

  always_comb begin
    fin_w  = need_r[ST_FADE][1] ? {1'b0, q_fin}  : ONE_Q16;
    fout_w = need_r[ST_FADE][0] ? {1'b0, q_fout} : ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (ld[ST_P1]) begin
      p1_r <= fin_w * fout_w;
    end
    if (ld[ST_P2]) begin
      p2_r <= p1_r[33:16] * cfg.max_alpha;
    end
    if (ld[ST_OUT]) begin
      op_r <= (p2_r[34:16] > 19'(ONE_Q16)) ? ONE_Q16 : p2_r[32:16];
    end
  end

  assign opacity = op_r;
  assign radius  = rad_r[ST_OUT];

endmodule

@@ design/particle_update_step_top.sv @@
// Throughput: one particle per cycle while the output is not stalled; the 17-stage ramp
// divider and 16-stage fade dividers each retire one quotient bit per stage, so the pipeline is 38 stages deep.
// Reset (synchronous, rst_n low) empties the pipeline and loads register defaults;
// no clearing pass follows.
module particle_update_step_top import pus_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_alive_in,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  input  logic [30:0] in_age,
  input  logic [15:0] in_frame_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_alive_out,
  output logic [31:0] out_new_pos_x,
  output logic [31:0] out_new_pos_y,
  output logic [31:0] out_new_pos_z,
  output logic [31:0] out_new_vel_x,
  output logic [31:0] out_new_vel_y,
  output logic [31:0] out_new_vel_z,
  output logic [16:0] out_opacity,
  output logic [31:0] out_radius,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_t          cfg_r;
  particle_t     in_r;
  logic [NS-1:0] ld;
  motion_t       mo;
  logic [16:0]   ramp;
  logic [16:0]   op;
  logic [31:0]   rad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity      <= 48'hF60000000000;
      cfg_r.drag         <= 18'd65536;
      cfg_r.life_time    <= 32'd65536;
      cfg_r.fade_in      <= 17'd0;
      cfg_r.fade_out     <= 17'd16384;
      cfg_r.max_alpha    <= 17'd65536;
      cfg_r.start_radius <= 32'd65536;
      cfg_r.end_radius   <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAVITY:      cfg_r.gravity      <= cfg_data;
        CFG_DRAG:         cfg_r.drag         <= cfg_data[17:0];
        CFG_LIFE_TIME:    cfg_r.life_time    <= cfg_data[31:0];
        CFG_FADE_IN:      cfg_r.fade_in      <= cfg_data[16:0];
        CFG_FADE_OUT:     cfg_r.fade_out     <= cfg_data[16:0];
        CFG_MAX_ALPHA:    cfg_r.max_alpha    <= cfg_data[16:0];
        CFG_START_RADIUS: cfg_r.start_radius <= cfg_data[31:0];
        CFG_END_RADIUS:   cfg_r.end_radius   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (ld[ST_IN]) begin
      in_r.alive  <= in_alive_in;
      in_r.pos[0] <= in_pos_x;
      in_r.pos[1] <= in_pos_y;
      in_r.pos[2] <= in_pos_z;
      in_r.vel[0] <= in_vel_x;
      in_r.vel[1] <= in_vel_y;
      in_r.vel[2] <= in_vel_z;
      in_r.age    <= in_age;
      in_r.dt     <= in_frame_step;
    end
  end

  pus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ld        (ld)
  );

  pus_motion u_motion (
    .clk (clk),
    .ld  (ld),
    .p   (in_r),
    .cfg (cfg_r),
    .mo  (mo)
  );

  pus_ramp_div u_ramp (
    .clk       (clk),
    .ld        (ld),
    .age       (in_r.age),
    .life_time (cfg_r.life_time),
    .ramp      (ramp)
  );

  pus_shade u_shade (
    .clk     (clk),
    .ld      (ld),
    .ramp    (ramp),
    .cfg     (cfg_r),
    .opacity (op),
    .radius  (rad)
  );

  assign out_alive_out = mo.live;
  assign out_new_pos_x = mo.pos[0];
  assign out_new_pos_y = mo.pos[1];
  assign out_new_pos_z = mo.pos[2];
  assign out_new_vel_x = mo.vel[0];
  assign out_new_vel_y = mo.vel[1];
  assign out_new_vel_z = mo.vel[2];
  assign out_opacity   = mo.live ? op  : '0;
  assign out_radius    = mo.live ? rad : '0;

endmodule
